// ===== hdl/ssp_pkg.sv =====
package ssp_pkg;

  // Full turn in degrees, the divisor of the shared divider
  localparam logic [8:0] DEG_FULL = 9'd360;

  // Configuration register indexes
  localparam logic [1:0] CFG_BASE = 2'd0;
  localparam logic [1:0] CFG_MULT = 2'd1;
  localparam logic [1:0] CFG_HALF = 2'd2;

  // Honored microstep factors and their mode pin patterns
  localparam logic [5:0] MULT_X8   = 6'd8;
  localparam logic [5:0] MULT_X32  = 6'd32;
  localparam logic [2:0] MODE_X1   = 3'd0;
  localparam logic [2:0] MODE_X8   = 3'd3;
  localparam logic [2:0] MODE_X32  = 3'd7;

  // Reset values of the configuration registers
  localparam logic [10:0] BASE_RESET = 11'd200;
  localparam logic [5:0]  MULT_RESET = 6'd1;
  localparam logic [15:0] HALF_RESET = 16'd500;

  typedef logic [3:0] pc_t;

  // Datapath operations selected by the control word
  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD_ABS,
    OP_FIX_MOD,
    OP_MUL,
    OP_DIFF,
    OP_WRAP,
    OP_TICK,
    OP_EMIT
  } op_t;

  // Jump conditions: jump to target when true, else advance
  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_NO_ACCEPT,
    C_NOT_START,
    C_DIV_BUSY,
    C_OUT_BLOCKED
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  // Program entry points
  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_DIV1 = 4'd3;
  localparam pc_t PC_DIV2 = 4'd6;
  localparam pc_t PC_TICK = 4'd9;
  localparam pc_t PC_EMIT = 4'd10;

  // Control store
  function automatic ctrl_word_t ucode_rom(input pc_t addr);
    ctrl_word_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: PC_IDLE};
    unique case (addr)
      4'd0:  w = '{op: OP_ACCEPT,   cond: C_NO_ACCEPT,   target: PC_IDLE};
      4'd1:  w = '{op: OP_NOP,      cond: C_NOT_START,   target: PC_TICK};
      4'd2:  w = '{op: OP_LOAD_ABS, cond: C_NEXT,        target: PC_IDLE};
      4'd3:  w = '{op: OP_NOP,      cond: C_DIV_BUSY,    target: PC_DIV1};
      4'd4:  w = '{op: OP_FIX_MOD,  cond: C_NEXT,        target: PC_IDLE};
      4'd5:  w = '{op: OP_MUL,      cond: C_NEXT,        target: PC_IDLE};
      4'd6:  w = '{op: OP_NOP,      cond: C_DIV_BUSY,    target: PC_DIV2};
      4'd7:  w = '{op: OP_DIFF,     cond: C_NEXT,        target: PC_IDLE};
      4'd8:  w = '{op: OP_WRAP,     cond: C_ALWAYS,      target: PC_EMIT};
      4'd9:  w = '{op: OP_TICK,     cond: C_NEXT,        target: PC_IDLE};
      4'd10: w = '{op: OP_EMIT,     cond: C_OUT_BLOCKED, target: PC_EMIT};
      4'd11: w = '{op: OP_NOP,      cond: C_ALWAYS,      target: PC_IDLE};
      default: w = '{op: OP_NOP,    cond: C_ALWAYS,      target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== hdl/ssp_div.sv =====
module ssp_div #(
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  output logic          busy,
  output logic [DW-1:0] quotient,
  output logic [8:0]    remainder
);
  import ssp_pkg::*;

  // Reciprocal of 360 scaled by 2^DW, rounded down: the first quotient
  // estimate is exact or one low
  localparam int MW = DW - 8;
  localparam int PW = DW + MW;
  localparam logic [MW-1:0] RECIP  = MW'((64'd1 << DW) / 64'(DEG_FULL));
  localparam logic [9:0]    FULL_W = 10'(DEG_FULL);

  logic [DW-1:0] x_r, x_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [DW-1:0] quo_r, quo_nxt;
  logic [9:0]    res_r, res_nxt;
  logic [8:0]    rem_r, rem_nxt;
  logic [2:0]    vld_r, vld_nxt;
  logic [9:0]    q_full_lo;

  // Multiply by the reciprocal, form the remainder, then correct once
  always_comb begin
    x_nxt     = x_r;
    prod_nxt  = prod_r;
    quo_nxt   = quo_r;
    res_nxt   = res_r;
    rem_nxt   = rem_r;
    // the remainder is below 720, so ten low bits of quotient * 360 suffice
    q_full_lo = 10'(prod_r[DW+9:DW] * FULL_W);
    vld_nxt   = start ? 3'b001 : {vld_r[1:0], 1'b0};
    if (start) begin
      x_nxt = dividend;
    end
    if (vld_r[0]) begin
      prod_nxt = PW'(x_r) * PW'(RECIP);
    end
    if (vld_r[1]) begin
      quo_nxt = DW'(prod_r[PW-1:DW]);
      res_nxt = x_r[9:0] - q_full_lo;
    end
    if (vld_r[2]) begin
      if (res_r >= FULL_W) begin
        quo_nxt = quo_r + DW'(1);
        rem_nxt = 9'(res_r - FULL_W);
      end else begin
        rem_nxt = res_r[8:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    prod_r <= prod_nxt;
    quo_r  <= quo_nxt;
    res_r  <= res_nxt;
    rem_r  <= rem_nxt;
  end

  assign busy      = |vld_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/stepper_shortest_path_positioner_core.sv =====
// Stepper positioner: takes time ticks and move commands on the in_ channel,
// one result per transaction on the out_ channel showing the state after it.
// A move command turns its angle into a step target within one revolution,
// picks the shorter way round and starts pulsing; each later tick advances
// the step/dir pulse timing, checks the fault line and ends the move.
// Configuration is written on cfg_we with cfg_index/cfg_wdata; writes that
// arrive while a move is in progress are dropped.
// A tick, or a move command while busy, goes from accept straight to the tick
// and emit steps without the divider. A move command while idle first makes
// two passes through the reciprocal divide-by-360 unit, then emits.
// The microcode sequencer accepts the next transaction while a result still
// waits in the output register; if the receiver stalls, it holds at the
// emit step until the register frees up, then returns to idle.
// Synchronous active-low reset: program counter to idle, position zero, no
// move, output register empty, configuration to 200 / 1 / 500.
module stepper_shortest_path_positioner_core #(
  parameter int POS_BITS = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic signed [15:0]  in_target_degree,
  input  logic                in_fault_n,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_step_out,
  output logic                out_dir_out,
  output logic                out_enable_n,
  output logic [2:0]          out_mode_bits,
  output logic                out_busy_res,
  output logic                out_fault_seen,
  output logic                out_command_ignored,
  output logic [POS_BITS-1:0] out_position,
  // configuration port
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [15:0]         cfg_wdata
);
  import ssp_pkg::*;

  localparam int DW = POS_BITS + 10;
  localparam int TW = POS_BITS + 1;
  localparam int XW = (TW > 17) ? TW : 17;
  localparam int SW = POS_BITS + 2;

  // Sequencer
  pc_t        pc_r, pc_nxt;
  ctrl_word_t ctl;
  logic       jump;

  // Configuration
  logic [10:0] cfg_base_r;
  logic [5:0]  cfg_mult_r;
  logic [15:0] cfg_half_r;

  // Latched transaction
  logic        act_r, act_nxt;
  logic [15:0] deg_in_r, deg_in_nxt;
  logic        fault_n_r, fault_n_nxt;

  // Move state
  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic [POS_BITS-1:0] target_r, target_nxt;
  logic [POS_BITS-1:0] steps_r, steps_nxt;
  logic                dir_r, dir_nxt;
  logic [15:0]         phase_r, phase_nxt;
  logic                pulse_r, pulse_nxt;
  logic                moving_r, moving_nxt;
  logic                fault_r, fault_nxt;
  logic                ignored_r, ignored_nxt;

  // Arithmetic scratch
  logic [TW-1:0]        tsteps_r, tsteps_nxt;
  logic [8:0]           angle_r, angle_nxt;
  logic                 neg_r, neg_nxt;
  logic signed [SW-1:0] diff_r, diff_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic                o_step_r, o_dir_r, o_en_n_r, o_busy_r, o_fault_r, o_ign_r;
  logic [2:0]          o_mode_r;
  logic [POS_BITS-1:0] o_pos_r;
  logic                out_blocked, emit_go;

  // Divider hookup
  logic          div_start, div_busy;
  logic [DW-1:0] div_dividend, div_quo;
  logic [8:0]    div_rem;

  // Combinational helpers
  logic [10:0]          base_eff;
  logic [2:0]           mult_shift;
  logic [2:0]           mode_pins;
  logic [XW-1:0]        t_raw, t_cap;
  logic [16:0]          deg_abs;
  logic [DW-1:0]        product;
  logic [15:0]          half_eff, half_m1;
  logic signed [SW-1:0] half_s, t_s, diff_adj, diff_mag;

  ssp_div #(.DW(DW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .busy      (div_busy),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Fetch control word and resolve jump
  assign ctl = ucode_rom(pc_r);

  always_comb begin
    unique case (ctl.cond)
      C_NEXT:        jump = 1'b0;
      C_ALWAYS:      jump = 1'b1;
      C_NO_ACCEPT:   jump = !in_valid;
      C_NOT_START:   jump = !act_r || moving_r;
      C_DIV_BUSY:    jump = div_busy;
      C_OUT_BLOCKED: jump = out_blocked;
      default:       jump = 1'b1;
    endcase
    pc_nxt = jump ? ctl.target : pc_t'(pc_r + pc_t'(1));
  end

  assign in_ready    = ctl.op == OP_ACCEPT;
  assign out_blocked = out_valid_r && !out_ready;
  assign emit_go     = (ctl.op == OP_EMIT) && !out_blocked;

  // Steps per revolution, microstep decode
  always_comb begin
    base_eff = (cfg_base_r == 11'd0) ? 11'd1 : cfg_base_r;
    if (cfg_mult_r == MULT_X8) begin
      mult_shift = 3'd3;
      mode_pins  = MODE_X8;
    end else if (cfg_mult_r == MULT_X32) begin
      mult_shift = 3'd5;
      mode_pins  = MODE_X32;
    end else begin
      mult_shift = 3'd0;
      mode_pins  = MODE_X1;
    end
    t_raw = XW'(base_eff) << mult_shift;
    t_cap = (t_raw > (XW'(1) << POS_BITS)) ? (XW'(1) << POS_BITS) : t_raw;
  end

  // Datapath helpers
  always_comb begin
    deg_abs  = deg_in_r[15] ? 17'(-$signed({deg_in_r[15], deg_in_r}))
                            : {1'b0, deg_in_r};
    product  = DW'(angle_r) * DW'(tsteps_r);
    half_s   = $signed({2'b00, tsteps_r[TW-1:1]});
    t_s      = $signed({1'b0, tsteps_r});
    if (diff_r > half_s)       diff_adj = diff_r - t_s;
    else if (diff_r < -half_s) diff_adj = diff_r + t_s;
    else                       diff_adj = diff_r;
    diff_mag = diff_adj[SW-1] ? -diff_adj : diff_adj;
    half_eff = (cfg_half_r == 16'd0) ? 16'd1 : cfg_half_r;
    half_m1  = half_eff - 16'd1;
  end

  // Datapath operations
  always_comb begin
    act_nxt      = act_r;
    deg_in_nxt   = deg_in_r;
    fault_n_nxt  = fault_n_r;
    pos_nxt      = pos_r;
    target_nxt   = target_r;
    steps_nxt    = steps_r;
    dir_nxt      = dir_r;
    phase_nxt    = phase_r;
    pulse_nxt    = pulse_r;
    moving_nxt   = moving_r;
    fault_nxt    = fault_r;
    ignored_nxt  = ignored_r;
    tsteps_nxt   = tsteps_r;
    angle_nxt    = angle_r;
    neg_nxt      = neg_r;
    diff_nxt     = diff_r;
    div_start    = 1'b0;
    div_dividend = DW'(deg_abs);
    unique case (ctl.op)
      OP_ACCEPT: begin
        if (in_valid) begin
          act_nxt     = in_action;
          deg_in_nxt  = in_target_degree;
          fault_n_nxt = in_fault_n;
          fault_nxt   = 1'b0;
          ignored_nxt = 1'b0;
        end
      end
      OP_LOAD_ABS: begin
        // reduce |angle| mod 360, latch revolution size
        div_start  = 1'b1;
        neg_nxt    = deg_in_r[15];
        tsteps_nxt = t_cap[TW-1:0];
      end
      OP_FIX_MOD: begin
        angle_nxt = (neg_r && div_rem != 9'd0) ? 9'(DEG_FULL - div_rem) : div_rem;
      end
      OP_MUL: begin
        // target = angle * steps / 360
        div_start    = 1'b1;
        div_dividend = product;
      end
      OP_DIFF: begin
        target_nxt = div_quo[POS_BITS-1:0];
        diff_nxt   = $signed(SW'(div_quo[POS_BITS-1:0])) - $signed(SW'(pos_r));
      end
      OP_WRAP: begin
        // take the short way round; start only when there is somewhere to go
        if (diff_adj != '0) begin
          dir_nxt    = !diff_adj[SW-1];
          steps_nxt  = diff_mag[POS_BITS-1:0];
          phase_nxt  = '0;
          pulse_nxt  = 1'b0;
          moving_nxt = 1'b1;
        end
      end
      OP_TICK: begin
        if (act_r) begin
          ignored_nxt = moving_r;
        end else if (moving_r) begin
          if (phase_r != 16'd0) begin
            phase_nxt = phase_r - 16'd1;
          end else if (pulse_r) begin
            pulse_nxt = 1'b0;
            phase_nxt = half_m1;
          end else if (steps_r == '0 || !fault_n_r) begin
            // finish or abort: position lands on the planned target
            fault_nxt  = (steps_r != '0);
            pos_nxt    = target_r;
            moving_nxt = 1'b0;
            pulse_nxt  = 1'b0;
            phase_nxt  = '0;
            steps_nxt  = '0;
          end else begin
            pulse_nxt = 1'b1;
            phase_nxt = half_m1;
            steps_nxt = steps_r - POS_BITS'(1);
          end
        end
      end
      OP_NOP, OP_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // Output register handoff
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go)        out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= PC_IDLE;
      cfg_base_r  <= BASE_RESET;
      cfg_mult_r  <= MULT_RESET;
      cfg_half_r  <= HALF_RESET;
      pos_r       <= '0;
      steps_r     <= '0;
      dir_r       <= 1'b0;
      phase_r     <= '0;
      pulse_r     <= 1'b0;
      moving_r    <= 1'b0;
      fault_r     <= 1'b0;
      ignored_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      pos_r       <= pos_nxt;
      steps_r     <= steps_nxt;
      dir_r       <= dir_nxt;
      phase_r     <= phase_nxt;
      pulse_r     <= pulse_nxt;
      moving_r    <= moving_nxt;
      fault_r     <= fault_nxt;
      ignored_r   <= ignored_nxt;
      out_valid_r <= out_valid_nxt;
      // drop writes during a move
      if (cfg_we && !moving_r) begin
        case (cfg_index)
          CFG_BASE: cfg_base_r <= cfg_wdata[10:0];
          CFG_MULT: cfg_mult_r <= cfg_wdata[5:0];
          CFG_HALF: cfg_half_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    deg_in_r  <= deg_in_nxt;
    fault_n_r <= fault_n_nxt;
    target_r  <= target_nxt;
    tsteps_r  <= tsteps_nxt;
    angle_r   <= angle_nxt;
    neg_r     <= neg_nxt;
    diff_r    <= diff_nxt;
    if (emit_go) begin
      o_step_r  <= pulse_r;
      o_dir_r   <= dir_r;
      o_en_n_r  <= !moving_r;
      o_mode_r  <= mode_pins;
      o_busy_r  <= moving_r;
      o_fault_r <= fault_r;
      o_ign_r   <= ignored_r;
      o_pos_r   <= pos_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_step_out        = o_step_r;
  assign out_dir_out         = o_dir_r;
  assign out_enable_n        = o_en_n_r;
  assign out_mode_bits       = o_mode_r;
  assign out_busy_res        = o_busy_r;
  assign out_fault_seen      = o_fault_r;
  assign out_command_ignored = o_ign_r;
  assign out_position        = o_pos_r;

  // A move ends only in the tick step and leaves the position inside the turn
  a_move_end: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(moving_r) && !moving_r) |->
      ($past(ctl.op) == OP_TICK && pos_r < POS_BITS'(tsteps_r)
       || tsteps_r[TW-1]))
    else $error("move ended outside tick step or position out of range");

  // The shared divider is never restarted while it is still working
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_LOAD_ABS || ctl.op == OP_MUL) |-> !div_busy)
    else $error("divider started while busy");

  // The step output is only high during a move
  a_pulse_moving: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_r |-> moving_r)
    else $error("step pulse high while idle");

endmodule
